/* sv/rhic_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rhic_pkg: shared types and constants of the half-space interval clip unit
// Function codes, controller states and the controller/datapath command set.
// ---------------------------------------------------------------------------
package rhic_pkg;

  localparam int unsigned W = 32;

  localparam logic [1:0] REG_ACTIVE_PLANES = 2'd0;

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_RAY   = 2'd1,
    FN_POINT = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_MUL,
    ST_SUM,
    ST_DIVST,
    ST_DIV,
    ST_UPD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic clr_idx;
    logic rd;
    logic mul;
    logic sum;
    logic div_start;
    logic div_step;
    logic update;
    logic inc_idx;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic       last_plane;
    logic       no_planes;
    logic       slot_ok;
    logic       parallel;
    logic       keep;
    logic       div_done;
    logic [1:0] func;
  } sts_t;

endpackage : rhic_pkg
`default_nettype wire

/* sv/ray_halfspace_interval_clip_unit.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// ray_halfspace_interval_clip_unit: ray and point clipping against half-spaces
// Loads plane items into a table, clips ray intervals and tests points.
// ---------------------------------------------------------------------------
// Sequence: a load, a no-op or a query with no planes goes from ST_RD to ST_OUT;
//   a query reads, multiplies, sums and updates per plane, and a ray query on
//   a plane not parallel to the ray runs the 66-step restoring divider too.
// Queries stop at the first plane that rejects. One item at a time; the next
//   is taken at the edge where the result leaves, or later under out_stall.
// Reset (rst_n, synchronous): controller idle, active_planes 0, table unset.
module ray_halfspace_interval_clip_unit
  import rhic_pkg::*;
#(
  parameter int unsigned MAX_PLANES = 8,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [1:0]          cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_func,
  input  wire logic [2:0]          in_plane_slot,
  input  wire logic signed [31:0]  in_dir_x,
  input  wire logic signed [31:0]  in_dir_y,
  input  wire logic signed [31:0]  in_dir_z,
  input  wire logic signed [31:0]  in_org_x,
  input  wire logic signed [31:0]  in_org_y,
  input  wire logic signed [31:0]  in_org_z,
  input  wire logic signed [31:0]  in_plane_offset_in,
  input  wire logic signed [31:0]  in_near_in,
  input  wire logic signed [31:0]  in_far_in,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_hit,
  output logic signed [31:0]       out_near_out,
  output logic signed [31:0]       out_far_out
);

  logic [3:0] active_planes_r;
  cmd_t cmd;
  sts_t sts;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_ACTIVE_PLANES) ? {28'd0, active_planes_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) active_planes_r <= '0;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_ACTIVE_PLANES)
      active_planes_r <= cfg_pwdata[3:0];
  end

  rhic_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  rhic_datapath #(.MAX_PLANES(MAX_PLANES), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .active_planes(active_planes_r),
    .in_func, .in_plane_slot, .in_dir_x, .in_dir_y, .in_dir_z,
    .in_org_x, .in_org_y, .in_org_z, .in_plane_offset_in,
    .in_near_in, .in_far_in,
    .res_hit(out_hit), .res_near(out_near_out), .res_far(out_far_out)
  );

endmodule : ray_halfspace_interval_clip_unit
`default_nettype wire

/* sv/rhic_datapath.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rhic_datapath: plane table, dot products, divider and interval update
// Three shared multipliers, a restoring divider one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rhic_datapath
  import rhic_pkg::*;
#(
  parameter int unsigned MAX_PLANES = 8,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  input  wire logic [3:0]           active_planes,
  input  wire logic [1:0]           in_func,
  input  wire logic [2:0]           in_plane_slot,
  input  wire logic signed [W-1:0]  in_dir_x,
  input  wire logic signed [W-1:0]  in_dir_y,
  input  wire logic signed [W-1:0]  in_dir_z,
  input  wire logic signed [W-1:0]  in_org_x,
  input  wire logic signed [W-1:0]  in_org_y,
  input  wire logic signed [W-1:0]  in_org_z,
  input  wire logic signed [W-1:0]  in_plane_offset_in,
  input  wire logic signed [W-1:0]  in_near_in,
  input  wire logic signed [W-1:0]  in_far_in,
  output logic                      res_hit,
  output logic signed [W-1:0]       res_near,
  output logic signed [W-1:0]       res_far
);

  localparam int unsigned IW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int unsigned CW = $clog2(MAX_PLANES + 1);
  localparam int unsigned QB = 32 + 1;
  localparam int unsigned DW = 66 - FRAC_BITS;
  localparam int unsigned SCW = $clog2(W + 2);

  logic signed [W-1:0] nx_mem [MAX_PLANES];
  logic signed [W-1:0] ny_mem [MAX_PLANES];
  logic signed [W-1:0] nz_mem [MAX_PLANES];
  logic signed [W-1:0] of_mem [MAX_PLANES];

  logic [1:0]          func_r;
  logic [2:0]          slot_r;
  logic signed [W-1:0] dx_r, dy_r, dz_r, ox_r, oy_r, oz_r, off_in_r;
  logic signed [W-1:0] near_r, far_r;
  logic                hit_r;
  logic [IW-1:0]       idx_r;
  logic [CW-1:0]       cnt_r;

  logic signed [W-1:0] nx_r, ny_r, nz_r, of_r;
  logic signed [63:0]  pd_r [3];
  logic signed [63:0]  po_r [3];
  logic                phase_r;
  logic signed [DW-1:0] den_r, od_r;

  logic [DW-1:0]       b_r;
  logic [DW:0]         rem_r;
  logic [DW-1:0]       a_r;
  logic [QB-1:0]       q_r;
  logic                neg_r;
  logic [SCW+2:0]      step_r;
  logic [SCW+2:0]      nsteps_r;
  logic signed [W-1:0] d_r;

  logic [CW-1:0] cnt_cl;
  always_comb begin
    cnt_cl = (32'(active_planes) > MAX_PLANES) ? CW'(MAX_PLANES) : CW'(active_planes);
  end

  always_ff @(posedge clk) begin
    if (cmd.load && 32'(slot_r) < MAX_PLANES) begin
      nx_mem[IW'(slot_r)] <= dx_r;
      ny_mem[IW'(slot_r)] <= dy_r;
      nz_mem[IW'(slot_r)] <= dz_r;
      of_mem[IW'(slot_r)] <= off_in_r;
    end
    if (cmd.rd) begin
      nx_r <= nx_mem[idx_r];
      ny_r <= ny_mem[idx_r];
      nz_r <= nz_mem[idx_r];
      of_r <= of_mem[idx_r];
    end
  end

  function automatic logic signed [DW-1:0] fl(input logic signed [63:0] p);
    fl = DW'(p >>> FRAC_BITS);
  endfunction

  logic signed [W-1:0] ma0, ma1, ma2;
  always_comb begin
    ma0 = phase_r ? ox_r : dx_r;
    ma1 = phase_r ? oy_r : dy_r;
    ma2 = phase_r ? oz_r : dz_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else if (cmd.mul) begin
      phase_r <= ~phase_r;
    end else if (cmd.rd) begin
      phase_r <= 1'b0;
    end
    if (cmd.mul) begin
      if (phase_r) begin
        po_r[0] <= ma0 * nx_r;
        po_r[1] <= ma1 * ny_r;
        po_r[2] <= ma2 * nz_r;
      end else begin
        pd_r[0] <= ma0 * nx_r;
        pd_r[1] <= ma1 * ny_r;
        pd_r[2] <= ma2 * nz_r;
      end
    end
    if (cmd.sum) begin
      den_r <= fl(pd_r[0]) + fl(pd_r[1]) + fl(pd_r[2]);
      od_r  <= fl(po_r[0]) + fl(po_r[1]) + fl(po_r[2]);
    end
  end

  logic signed [DW-1:0] num;
  logic                 par;
  always_comb begin
    num = DW'(of_r) - od_r;
    par = (den_r == '0);
  end

  logic [DW:0] rsh;
  logic        ge;
  always_comb begin
    rsh = {rem_r[DW-1:0], a_r[DW-1]};
    ge  = (rsh >= {1'b0, b_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      a_r      <= num[DW-1] ? DW'(-num) : DW'(num);
      b_r      <= den_r[DW-1] ? DW'(-den_r) : DW'(den_r);
      neg_r    <= num[DW-1] ^ den_r[DW-1];
      rem_r    <= '0;
      q_r      <= '0;
      step_r   <= '0;
      nsteps_r <= (SCW+3)'(DW) + (SCW+3)'(FRAC_BITS);
    end else if (cmd.div_step) begin
      a_r    <= {a_r[DW-2:0], 1'b0};
      rem_r  <= ge ? rsh - {1'b0, b_r} : rsh;
      q_r    <= (q_r[QB-1] == 1'b1) ? q_r : {q_r[QB-2:0], ge};
      step_r <= step_r + 1'b1;
    end
  end

  logic signed [W-1:0] dq;
  always_comb begin
    if (neg_r) dq = (q_r > QB'(33'h080000000)) ? 32'sh80000000 : W'(-$signed({1'b0, q_r}));
    else       dq = (q_r > QB'(33'h07FFFFFFF)) ? 32'sh7FFFFFFF : W'(q_r);
  end

  logic keep;
  always_comb begin
    if (par || func_r == FN_POINT) keep = (DW'(of_r) > od_r);
    else if (!den_r[DW-1])         keep = (dq > near_r);
    else                           keep = (dq < far_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (cmd.capture) begin
        func_r <= in_func; slot_r <= in_plane_slot;
        dx_r <= in_dir_x; dy_r <= in_dir_y; dz_r <= in_dir_z;
        ox_r <= in_org_x; oy_r <= in_org_y; oz_r <= in_org_z;
        off_in_r <= in_plane_offset_in;
        near_r <= in_near_in; far_r <= in_far_in;
        cnt_r <= cnt_cl;
        hit_r <= 1'b1;
      end
      if (cmd.clr_idx) idx_r <= '0;
      else if (cmd.inc_idx) idx_r <= idx_r + 1'b1;
      if (cmd.load) hit_r <= (32'(slot_r) < MAX_PLANES);
      if (cmd.update) begin
        if (!keep) hit_r <= 1'b0;
        else if (!par && func_r == FN_RAY) begin
          if (!den_r[DW-1]) begin
            if (dq < far_r) far_r <= dq;
          end else if (dq > near_r) near_r <= dq;
        end
      end
    end
  end

  always_comb begin
    sts.last_plane = (CW'(idx_r) + 1'b1 >= cnt_r);
    sts.no_planes  = (cnt_r == '0);
    sts.slot_ok    = (32'(slot_r) < MAX_PLANES);
    sts.parallel   = par;
    sts.keep       = keep;
    sts.div_done   = (step_r == nsteps_r);
    sts.func       = func_r;
    res_hit  = hit_r && (func_r != FN_NONE);
    res_near = (hit_r && func_r == FN_RAY) ? near_r : '0;
    res_far  = (hit_r && func_r == FN_RAY) ? far_r : '0;
  end

  logic unused;
  assign unused = cmd.finish ^ d_r[0];
  always_ff @(posedge clk) if (cmd.update) d_r <= dq;

endmodule : rhic_datapath
`default_nettype wire

/* sv/rhic_ctrl.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rhic_ctrl: sequencer of the clip unit
// Walks the active planes, issues datapath commands, owns the handshakes.
// ---------------------------------------------------------------------------
module rhic_ctrl
  import rhic_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;
  logic   mph_r;

  logic take;
  assign in_stall = (state_r != ST_IDLE) || (ov_r && out_stall);
  assign take = in_valid && !in_stall;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (take) state_nxt = ST_RD;
      ST_RD: begin
        if (sts.func == FN_RAY || sts.func == FN_POINT)
          state_nxt = sts.no_planes ? ST_OUT : ST_MUL;
        else state_nxt = ST_OUT;
      end
      ST_MUL:  if (mph_r) state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_DIVST;
      ST_DIVST: begin
        if (sts.func == FN_POINT || sts.parallel) state_nxt = ST_UPD;
        else state_nxt = ST_DIV;
      end
      ST_DIV:  if (sts.div_done) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = (!sts.keep || sts.last_plane) ? ST_OUT : ST_RD;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    ov_nxt = ov_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        cmd.capture = take;
        cmd.clr_idx = take;
      end
      ST_RD: begin
        cmd.rd = 1'b1;
        cmd.load = (sts.func == FN_LOAD);
      end
      ST_MUL:   cmd.mul = 1'b1;
      ST_SUM:   cmd.sum = 1'b1;
      ST_DIVST: cmd.div_start = 1'b1;
      ST_DIV:   cmd.div_step = !sts.div_done;
      ST_UPD: begin
        cmd.update  = 1'b1;
        cmd.inc_idx = 1'b1;
      end
      ST_OUT: begin
        cmd.finish = 1'b1;
        ov_nxt = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      mph_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      mph_r   <= (state_r == ST_MUL) ? ~mph_r : 1'b0;
    end
  end

  a_out_only_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r) == ST_OUT) else $error("result without work");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !take) else $error("item taken while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> ov_r) else $error("result dropped");

endmodule : rhic_ctrl
`default_nettype wire

/* sim/ray_halfspace_interval_clip_unit_tb.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// ray_halfspace_interval_clip_unit_tb: testbench of the half-space clip unit
// A directed table followed by random plane loads, ray clips and point tests.
// Each result is checked against an in-bench clip predictor or a typed row's
// expected result, under random sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module ray_halfspace_interval_clip_unit_tb;
  import rhic_pkg::*;

  localparam int          NPLANES = 8;
  localparam int          FRAC    = 16;
  localparam int          N_RAND  = 1950;
  localparam longint      LIMIT   = 6_000_000;
  localparam logic signed [31:0] ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;

  typedef struct {
    func_t              func;
    logic [2:0]         slot;
    logic signed [31:0] dx, dy, dz, ox, oy, oz, off, nr, fr;
  } clip_req_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] nr, fr;
  } clip_res_t;

  typedef struct {
    int        set_planes;
    clip_req_t req;
    bit        typed;
    clip_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_func = '0;
  logic [2:0] in_plane_slot = '0;
  logic signed [31:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic signed [31:0] in_org_x = '0, in_org_y = '0, in_org_z = '0;
  logic signed [31:0] in_plane_offset_in = '0, in_near_in = '0, in_far_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic signed [31:0] out_near_out, out_far_out;

  ray_halfspace_interval_clip_unit dut (
    .clk, .rst_n,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready,
    .in_valid, .in_stall, .in_func, .in_plane_slot,
    .in_dir_x, .in_dir_y, .in_dir_z, .in_org_x, .in_org_y, .in_org_z,
    .in_plane_offset_in, .in_near_in, .in_far_in,
    .out_valid, .out_stall, .out_hit, .out_near_out, .out_far_out
  );

  always #2 clk = ~clk;

  // predictor state
  logic signed [31:0] nx_tab [NPLANES];
  logic signed [31:0] ny_tab [NPLANES];
  logic signed [31:0] nz_tab [NPLANES];
  logic signed [31:0] off_tab [NPLANES];
  logic [3:0] active_planes = '0;

  clip_res_t expected_q[$];
  int errors = 0;
  longint cycles = 0;
  int burst_left = 0;

  function automatic longint dot_q(logic signed [31:0] ax, ay, az, bx, by, bz);
    longint px, py, pz;
    px = longint'(ax) * longint'(bx);
    py = longint'(ay) * longint'(by);
    pz = longint'(az) * longint'(bz);
    return (px >>> FRAC) + (py >>> FRAC) + (pz >>> FRAC);
  endfunction

  function automatic longint sat_div(longint num, longint den);
    bit neg;
    longint unsigned a, b, qi, r, q;
    neg = (num < 0) != (den < 0);
    a = num < 0 ? longint'(-num) : num;
    b = den < 0 ? longint'(-den) : den;
    qi = a / b;
    r = a % b;
    if (qi >= (64'd1 << (32 - FRAC))) begin
      q = 64'd1 << 32;
    end else begin
      q = qi;
      for (int i = 0; i < FRAC; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= b) begin
          r = r - b;
          q = q | 64'd1;
        end
      end
    end
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return -longint'(q);
    end
    if (q > 64'h7fff_ffff) q = 64'h7fff_ffff;
    return longint'(q);
  endfunction

  function automatic clip_res_t clip_predict(clip_req_t r);
    clip_res_t res;
    int cnt;
    longint den, od, d, nv, fv;
    res = '{1'b0, '0, '0};
    cnt = active_planes > NPLANES ? NPLANES : active_planes;
    nv = r.nr;
    fv = r.fr;
    case (r.func)
      FN_LOAD: begin
        nx_tab[r.slot] = r.dx;
        ny_tab[r.slot] = r.dy;
        nz_tab[r.slot] = r.dz;
        off_tab[r.slot] = r.off;
        res.hit = 1'b1;
      end
      FN_RAY: begin
        res.hit = 1'b1;
        for (int i = 0; i < cnt && res.hit; i++) begin
          den = dot_q(r.dx, r.dy, r.dz, nx_tab[i], ny_tab[i], nz_tab[i]);
          od = dot_q(r.ox, r.oy, r.oz, nx_tab[i], ny_tab[i], nz_tab[i]);
          if (den == 0) begin
            if (!(od < longint'(off_tab[i]))) res.hit = 1'b0;
          end else begin
            d = sat_div(longint'(off_tab[i]) - od, den);
            if (den > 0) begin
              if (d <= nv) res.hit = 1'b0;
              else if (d < fv) fv = d;
            end else begin
              if (d >= fv) res.hit = 1'b0;
              else if (d > nv) nv = d;
            end
          end
        end
        if (res.hit) begin
          res.nr = nv[31:0];
          res.fr = fv[31:0];
        end
      end
      FN_POINT: begin
        res.hit = 1'b1;
        for (int i = 0; i < cnt; i++) begin
          od = dot_q(r.ox, r.oy, r.oz, nx_tab[i], ny_tab[i], nz_tab[i]);
          if (od >= longint'(off_tab[i])) res.hit = 1'b0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report(string what);
    errors++;
    $display("mismatch @%0d: %s", cycles, what);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    clip_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report("result with no item pending");
      end else begin
        e = expected_q.pop_front();
        if (out_hit !== e.hit)
          report($sformatf("hit %0b exp %0b", out_hit, e.hit));
        if (out_near_out !== e.nr)
          report($sformatf("near %h exp %h", out_near_out, e.nr));
        if (out_far_out !== e.fr)
          report($sformatf("far %h exp %h", out_far_out, e.fr));
      end
    end
  end

  // receiver stall pattern
  int stall_mode = 0;
  int stall_run = 0;
  always @(posedge clk) begin
    if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 2);
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: begin
          if ($urandom_range(0, 15) == 0) begin
            stall_run <= $urandom_range(5, 40);
            out_stall <= 1'b1;
          end else begin
            out_stall <= 1'b0;
          end
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  task automatic set_active_planes(logic [3:0] n);
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (20) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_ACTIVE_PLANES;
    cfg_pwdata <= 32'(n);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    active_planes = n;
  endtask

  task automatic send_item(clip_req_t r, bit typed, clip_res_t tres);
    clip_res_t p;
    in_func <= r.func;
    in_plane_slot <= r.slot;
    in_dir_x <= r.dx; in_dir_y <= r.dy; in_dir_z <= r.dz;
    in_org_x <= r.ox; in_org_y <= r.oy; in_org_z <= r.oz;
    in_plane_offset_in <= r.off;
    in_near_in <= r.nr;
    in_far_in <= r.fr;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = clip_predict(r);
    expected_q.insert(expected_q.size(), typed ? tres : p);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  function automatic dir_row_t mk(int sp, func_t f, int s,
      logic signed [31:0] dx, dy, dz, ox, oy, oz, off, nr, fr,
      bit typed = 0, logic eh = 0, logic signed [31:0] en = 0, ef = 0);
    dir_row_t w;
    w.set_planes = sp;
    w.req = '{f, 3'(s), dx, dy, dz, ox, oy, oz, off, nr, fr};
    w.typed = typed;
    w.res = '{eh, en, ef};
    return w;
  endfunction

  function automatic logic signed [31:0] rnd_val();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: case ($urandom_range(0, 4))
           0: return MAXV;
           1: return MINV;
           2: return 0;
           3: return -1;
           default: return 1;
         endcase
      2: return $signed($urandom_range(0, 32'h1f_ffff)) - 32'sh10_0000;
      default: return ($signed($urandom_range(0, 400)) - 200) * ONE
                      + $signed($urandom_range(0, 16'hffff));
    endcase
  endfunction

  function automatic logic signed [31:0] small_q(int mag);
    return ($signed($urandom_range(0, 2 * mag)) - mag) * ONE
           + $signed($urandom_range(0, 16'hffff));
  endfunction

  function automatic clip_req_t rnd_req();
    clip_req_t r;
    int k;
    bit tidy;
    k = $urandom_range(0, 99);
    tidy = $urandom_range(0, 9) < 7;
    r.func = k < 25 ? FN_LOAD : k < 65 ? FN_RAY : k < 95 ? FN_POINT : FN_NONE;
    r.slot = $urandom_range(0, 7);
    if (tidy && r.func == FN_LOAD) begin
      r.dx = 0; r.dy = 0; r.dz = 0;
      case ($urandom_range(0, 2))
        0: r.dx = small_q(4);
        1: r.dy = small_q(4);
        default: r.dz = small_q(4);
      endcase
      r.off = small_q(200);
      r.ox = rnd_val(); r.oy = rnd_val(); r.oz = rnd_val();
      r.nr = rnd_val(); r.fr = rnd_val();
    end else if (tidy) begin
      r.dx = small_q(4); r.dy = small_q(4); r.dz = small_q(4);
      r.ox = small_q(60); r.oy = small_q(60); r.oz = small_q(60);
      r.off = rnd_val();
      r.nr = -$signed($urandom_range(0, 600)) * ONE;
      r.fr = $signed($urandom_range(0, 600)) * ONE;
    end else begin
      r.dx = rnd_val(); r.dy = rnd_val(); r.dz = rnd_val();
      r.ox = rnd_val(); r.oy = rnd_val(); r.oz = rnd_val();
      r.off = rnd_val(); r.nr = rnd_val(); r.fr = rnd_val();
    end
    return r;
  endfunction

  dir_row_t dir_tab[$];
  logic [3:0] phase_planes[10] = '{8, 1, 15, 3, 0, 8, 5, 2, 12, 7};

  task automatic add_row(dir_row_t w);
    dir_tab.insert(dir_tab.size(), w);
  endtask

  initial begin
    // zero planes: interval passes through, even when reversed
    add_row(mk(-1, FN_RAY, 0, ONE, 0, 0, 0, 0, 0, 0, -5, 7, 1, 1, -5, 7));
    add_row(mk(-1, FN_RAY, 0, 0, 0, 0, 0, 0, 0, 0, 100, -100, 1, 1, 100, -100));
    add_row(mk(-1, FN_POINT, 0, 0, 0, 0, MAXV, MINV, 0, 0, 0, 0, 1, 1, 0, 0));
    add_row(mk(-1, FN_NONE, 7, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV,
               1, 0, 0, 0));
    // axis box of half-size 10, then a diagonal and an extreme plane
    add_row(mk(-1, FN_LOAD, 0, ONE, 0, 0, 0, 0, 0, 10 * ONE, 0, 0, 1, 1, 0, 0));
    add_row(mk(-1, FN_LOAD, 1, -ONE, 0, 0, 0, 0, 0, 10 * ONE, 0, 0, 1, 1, 0, 0));
    add_row(mk(-1, FN_LOAD, 2, 0, ONE, 0, 0, 0, 0, 10 * ONE, 0, 0, 1, 1, 0, 0));
    add_row(mk(-1, FN_LOAD, 3, 0, -ONE, 0, 0, 0, 0, 10 * ONE, 0, 0, 1, 1, 0, 0));
    add_row(mk(-1, FN_LOAD, 4, 0, 0, ONE, 0, 0, 0, 10 * ONE, 0, 0, 1, 1, 0, 0));
    add_row(mk(-1, FN_LOAD, 5, 0, 0, -ONE, 0, 0, 0, 10 * ONE, 0, 0, 1, 1, 0, 0));
    add_row(mk(-1, FN_LOAD, 6, ONE, ONE, ONE, 0, 0, 0, 1000 * ONE, 0, 0,
               1, 1, 0, 0));
    add_row(mk(-1, FN_LOAD, 7, MAXV, MINV, -1, 0, 0, 0, MAXV, 0, 0, 1, 1, 0, 0));
    add_row(mk(6, FN_RAY, 0, ONE, 0, 0, 0, 0, 0, 0, -1000 * ONE, 1000 * ONE));
    add_row(mk(-1, FN_RAY, 0, ONE, ONE / 2, -ONE, 0, ONE, 0, 0, MINV, MAXV));
    add_row(mk(-1, FN_POINT, 0, 0, 0, 0, 3 * ONE, -2 * ONE, ONE, 0, 0, 0));
    // on the boundary is outside
    add_row(mk(-1, FN_POINT, 0, 0, 0, 0, 10 * ONE, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    // parallel ray outside a plane
    add_row(mk(-1, FN_RAY, 0, 0, ONE, 0, 20 * ONE, 0, 0, 0, MINV, MAXV,
               1, 0, 0, 0));
    // tiny direction: saturating distance
    add_row(mk(-1, FN_RAY, 0, 1, 0, 0, 0, 0, 0, 0, MINV, MAXV));
    add_row(mk(8, FN_RAY, 0, MAXV, MINV, MAXV, MINV, MAXV, MINV, 0, MINV, MAXV));
    add_row(mk(-1, FN_RAY, 0, -1, 1, MINV, 0, -ONE, ONE, 0, -ONE, ONE));
    add_row(mk(-1, FN_POINT, 0, 0, 0, 0, MINV, MINV, MAXV, 0, 0, 0));
    add_row(mk(-1, FN_POINT, 0, 0, 0, 0, -ONE, 0, 0, 0, 0, 0));
    add_row(mk(15, FN_RAY, 0, ONE, 0, 0, 0, 0, 0, 0, 0, 5 * ONE));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i]) begin
      if (dir_tab[i].set_planes >= 0) set_active_planes(4'(dir_tab[i].set_planes));
      send_item(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);
    end
    for (int ph = 0; ph < 10; ph++) begin
      set_active_planes(phase_planes[ph]);
      for (int n = 0; n < N_RAND / 10; n++) send_item(rnd_req(), 0, '{0, 0, 0});
    end
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
